### hw/rtl/fara_pkg.sv
// Shared types, status codes and default sizes for the region allocator.
package fara_pkg;

    localparam int DATA_W          = 32;
    localparam int STATUS_W        = 3;
    localparam int COUNT_W         = 7;
    localparam int MAX_REGIONS_DEF = 64;
    localparam int ADDR_BITS_DEF   = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 3'd0,
        ST_START   = 3'd1,
        ST_END     = 3'd2,
        ST_OVERLAP = 3'd3,
        ST_BADFREE = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    // Compare results for one table entry against the request.
    typedef struct packed {
        logic overlap;
        logic left;
        logic right;
        logic match;
        logic above;
        logic below_min;
    } t_hit;

endpackage

### hw/rtl/fara_ram.sv
// Single-write, single-read table memory with registered read data.
module fara_ram
    import fara_pkg::*;
#(
    parameter int WIDTH  = 2 * DATA_W,
    parameter int DEPTH  = MAX_REGIONS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/fara_cmp.sv
// Compare unit that tests one stored region against the current request.
module fara_cmp
    import fara_pkg::*;
(
    input  logic [DATA_W-1:0] i_start,
    input  logic [DATA_W-1:0] i_length,
    input  logic [DATA_W-1:0] i_addr,
    input  logic [DATA_W:0]   i_end,
    input  logic [DATA_W-1:0] i_min,
    output t_hit              o_hit
);

    logic [DATA_W:0] w_entry_end;

    assign w_entry_end = {1'b0, i_start} + {1'b0, i_length};

    always_comb begin
        o_hit.overlap   = ({1'b0, i_addr} < w_entry_end) && ({1'b0, i_start} < i_end);
        o_hit.left      = (w_entry_end == {1'b0, i_addr});
        o_hit.right     = ({1'b0, i_start} == i_end);
        o_hit.match     = (i_start == i_addr);
        o_hit.above     = (i_start > i_addr);
        o_hit.below_min = (i_start < i_min);
    end

endmodule

### hw/rtl/fixed_address_region_allocator_unit.sv
// Region allocator top level: request sequencer, table scan and result register.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_command, i_address, i_region_size
//  out     | output    | o_out_valid / i_out_ready  | o_status, o_free_bytes,
//          |           |                            | o_regions_held, o_blocks_held
//  cfg     | input     | i_cfg_we (no wait)         | i_cfg_data
//
// An allocate passes the range check, then the table scan and the finish state; a free
// skips the range check, and an allocate rejected on range goes from the check straight
// to the result. The scan reads one table entry per cycle from the single-read table
// memory.
// Reset is synchronous and active low; it clears the valid bits and all counts.
// A stalled result waits in the output register; the next word is accepted meanwhile,
// and its result waits in the final state until the output register is free.
module fixed_address_region_allocator_unit
    import fara_pkg::*;
#(
    parameter int MAX_REGIONS = MAX_REGIONS_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [DATA_W-1:0]   i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_command,
    input  logic [DATA_W-1:0]   i_address,
    input  logic [DATA_W-1:0]   i_region_size,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [DATA_W-1:0]   o_free_bytes,
    output logic [COUNT_W-1:0]  o_regions_held,
    output logic [COUNT_W-1:0]  o_blocks_held
);

    localparam int IDX_W  = $clog2(MAX_REGIONS);
    localparam int SCAN_W = IDX_W + 1;
    localparam int CNT_W  = ($clog2(MAX_REGIONS + 1) > COUNT_W) ?
                            $clog2(MAX_REGIONS + 1) : COUNT_W;
    localparam int AW     = (ADDR_BITS < DATA_W) ? ADDR_BITS : DATA_W;
    localparam int ENT_W  = 2 * DATA_W;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FINISH = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state               r_state;
    logic [DATA_W-1:0]    r_arena;
    logic [DATA_W-1:0]    r_free;
    logic [CNT_W-1:0]     r_regions;
    logic [CNT_W-1:0]     r_blocks;
    logic [MAX_REGIONS-1:0] r_valid;
    logic                 r_out_valid;
    logic                 r_pv;

    logic                 r_cmd;
    logic [DATA_W-1:0]    r_addr;
    logic [DATA_W-1:0]    r_size;
    logic [DATA_W:0]      r_end;
    logic [SCAN_W-1:0]    r_cnt;
    logic [IDX_W-1:0]     r_pidx;
    logic                 r_pvld;
    logic                 r_overlap;
    logic                 r_left;
    logic                 r_right;
    logic                 r_match;
    logic [IDX_W-1:0]     r_match_idx;
    logic [DATA_W-1:0]    r_match_len;
    logic                 r_min_found;
    logic [DATA_W-1:0]    r_min;
    logic                 r_slot_found;
    logic [IDX_W-1:0]     r_slot;
    t_status              r_status;
    t_status              r_o_status;
    logic [DATA_W-1:0]    r_o_free;
    logic [COUNT_W-1:0]   r_o_regions;
    logic [COUNT_W-1:0]   r_o_blocks;

    logic [DATA_W-1:0]    w_addr;
    logic                 w_accept;
    logic                 w_issue;
    logic                 w_last;
    logic                 w_start_bad;
    logic                 w_end_bad;
    logic                 w_alloc_ok;
    logic                 w_free_ok;
    logic                 w_free_right;
    logic                 w_out_free;
    logic [ENT_W-1:0]     w_rdata;
    logic [DATA_W-1:0]    w_rd_start;
    logic [DATA_W-1:0]    w_rd_len;
    t_hit                 w_hit;

    assign w_addr      = DATA_W'(i_address[AW-1:0]);
    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_issue     = (r_state == S_SCAN) && (r_cnt < SCAN_W'(MAX_REGIONS));
    assign w_last      = r_pv && (r_pidx == IDX_W'(MAX_REGIONS - 1));
    assign w_out_free  = !r_out_valid || i_out_ready;

    assign w_start_bad = (r_addr >= r_arena);
    assign w_end_bad   = (r_size == '0) || (r_end > {1'b0, r_arena});

    assign w_alloc_ok  = (r_cmd == CMD_ALLOC) && !r_overlap && r_slot_found;
    assign w_free_ok   = (r_cmd == CMD_FREE) && r_match;
    // With no overlaps in the table, the right neighbor of a freed region can only be
    // the held region with the lowest start above it.
    assign w_free_right = r_min_found &&
                          ({1'b0, r_min} == ({1'b0, r_addr} + {1'b0, r_match_len}));

    assign w_rd_start = w_rdata[DATA_W-1:0];
    assign w_rd_len   = w_rdata[ENT_W-1:DATA_W];

    fara_ram #(
        .WIDTH  (ENT_W),
        .DEPTH  (MAX_REGIONS),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_FINISH) && w_alloc_ok),
        .i_waddr (r_slot),
        .i_wdata ({r_size, r_addr}),
        .i_raddr (r_cnt[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    fara_cmp u_cmp (
        .i_start  (w_rd_start),
        .i_length (w_rd_len),
        .i_addr   (r_addr),
        .i_end    (r_end),
        .i_min    (r_min),
        .o_hit    (w_hit)
    );

    // Control state and table bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_arena     <= '0;
            r_free      <= '0;
            r_regions   <= '0;
            r_blocks    <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_pv        <= 1'b0;
        end else begin
            r_pv <= w_issue;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_we) begin
                        r_arena   <= i_cfg_data;
                        r_free    <= i_cfg_data;
                        r_regions <= '0;
                        r_blocks  <= '0;
                        r_valid   <= '0;
                    end
                    if (i_in_valid) begin
                        r_state <= (i_command == CMD_FREE) ? S_SCAN : S_CHECK;
                    end
                end
                S_CHECK: begin
                    r_state <= (w_start_bad || w_end_bad) ? S_DONE : S_SCAN;
                end
                S_SCAN: begin
                    if (w_last) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_alloc_ok) begin
                        r_valid[r_slot] <= 1'b1;
                        r_free          <= r_free - r_size;
                        r_regions       <= r_regions + CNT_W'(1);
                        r_blocks        <= r_blocks + CNT_W'(1) - CNT_W'(r_left)
                                           - CNT_W'(r_right);
                    end else if (w_free_ok) begin
                        r_valid[r_match_idx] <= 1'b0;
                        r_free               <= r_free + r_match_len;
                        r_regions            <= r_regions - CNT_W'(1);
                        r_blocks             <= r_blocks + CNT_W'(r_left)
                                                + CNT_W'(w_free_right) - CNT_W'(1);
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Request, scan accumulators and result word.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd        <= i_command;
            r_addr       <= w_addr;
            r_size       <= i_region_size;
            r_end        <= {1'b0, w_addr} + {1'b0, i_region_size};
            r_cnt        <= '0;
            r_overlap    <= 1'b0;
            r_left       <= 1'b0;
            r_right      <= 1'b0;
            r_match      <= 1'b0;
            r_min_found  <= 1'b0;
            r_slot_found <= 1'b0;
        end
        if (r_state == S_CHECK) begin
            r_status <= w_start_bad ? ST_START : ST_END;
        end
        if (w_issue) begin
            r_cnt  <= r_cnt + SCAN_W'(1);
            r_pidx <= r_cnt[IDX_W-1:0];
            r_pvld <= r_valid[r_cnt[IDX_W-1:0]];
        end
        if ((r_state == S_SCAN) && r_pv) begin
            if (r_pvld) begin
                if (w_hit.overlap) begin
                    r_overlap <= 1'b1;
                end
                if (w_hit.left) begin
                    r_left <= 1'b1;
                end
                if (w_hit.right) begin
                    r_right <= 1'b1;
                end
                if (w_hit.match) begin
                    r_match     <= 1'b1;
                    r_match_idx <= r_pidx;
                    r_match_len <= w_rd_len;
                end
                if (w_hit.above && (!r_min_found || w_hit.below_min)) begin
                    r_min_found <= 1'b1;
                    r_min       <= w_rd_start;
                end
            end else if (!r_slot_found) begin
                r_slot_found <= 1'b1;
                r_slot       <= r_pidx;
            end
        end
        if (r_state == S_FINISH) begin
            if (r_cmd == CMD_FREE) begin
                r_status <= r_match ? ST_OK : ST_BADFREE;
            end else if (r_overlap) begin
                r_status <= ST_OVERLAP;
            end else if (!r_slot_found) begin
                r_status <= ST_FULL;
            end else begin
                r_status <= ST_OK;
            end
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_o_status  <= r_status;
            r_o_free    <= r_free;
            r_o_regions <= r_regions[COUNT_W-1:0];
            r_o_blocks  <= r_blocks[COUNT_W-1:0];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_o_status;
    assign o_free_bytes   = r_o_free;
    assign o_regions_held = r_o_regions;
    assign o_blocks_held  = r_o_blocks;

`ifndef SYNTHESIS
    // Every held region has exactly one valid table entry.
    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == int'(r_regions))
        else $error("region count differs from number of valid entries");

    // A run holds at least one region.
    a_blocks_le_regions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blocks <= r_regions)
        else $error("block count exceeds region count");

    // An arena write empties the table and reloads the free byte count.
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (r_state == S_IDLE) |=>
            (r_valid == '0) && (r_regions == '0) && (r_blocks == '0)
            && (r_free == $past(i_cfg_data)))
        else $error("arena write did not clear the table");

    // A failed request leaves the table untouched.
    a_fail_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && !w_alloc_ok && !w_free_ok |=>
            $stable(r_valid) && $stable(r_regions) && $stable(r_free))
        else $error("failed request changed the table");
`endif

endmodule

### tb/tb_fixed_address_region_allocator_unit.sv
// Self-checking testbench for the region allocator: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb_fixed_address_region_allocator_unit;
    import fara_pkg::*;

    localparam int MAX_R      = MAX_REGIONS_DEF;
    localparam int STALL_MAX  = 2000;
    localparam int TAIL_WAIT  = MAX_R + 16;
    localparam int PHASES     = 11;
    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   free_b;
        logic [COUNT_W-1:0]  regions;
        logic [COUNT_W-1:0]  blocks;
    } alloc_result_t;

    typedef enum logic { ROW_WORD, ROW_ARENA } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic          cmd;
        logic [31:0]   addr;
        logic [31:0]   size;
        logic          typed;
        alloc_result_t exp;
    } dir_row_t;

    logic                i_clk;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_we      = 1'b0;
    logic [DATA_W-1:0]   i_cfg_data    = '0;
    logic                i_in_valid    = 1'b0;
    logic                o_in_ready;
    logic                i_command     = CMD_ALLOC;
    logic [DATA_W-1:0]   i_address     = '0;
    logic [DATA_W-1:0]   i_region_size = '0;
    logic                o_out_valid;
    logic                i_out_ready   = 1'b0;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_free_bytes;
    logic [COUNT_W-1:0]  o_regions_held;
    logic [COUNT_W-1:0]  o_blocks_held;

    fixed_address_region_allocator_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_address      (i_address),
        .i_region_size  (i_region_size),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_status       (o_status),
        .o_free_bytes   (o_free_bytes),
        .o_regions_held (o_regions_held),
        .o_blocks_held  (o_blocks_held)
    );

    // Shadow copy of the allocation table.
    logic        held_used [MAX_R];
    logic [63:0] held_base [MAX_R];
    logic [63:0] held_len  [MAX_R];
    logic [31:0] model_arena;
    logic [31:0] model_free;
    int          model_regions;
    int          model_blocks;
    int          peak_regions;

    alloc_result_t pending_results[$];
    dir_row_t      dir_rows[$];

    logic          cur_typed = 1'b0;
    alloc_result_t cur_exp   = '0;

    int send_pct   = 0;
    int recv_pct   = 0;
    int errors     = 0;
    int mismatches = 0;
    int words_in   = 0;
    int words_out  = 0;
    int arena_writes = 0;
    int stall_cycles = 0;
    int status_seen [8];

    logic [31:0] ph_arena [PHASES];
    int          ph_items [PHASES];
    int          ph_mode  [PHASES];
    bit          ph_fill  [PHASES];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void clear_model();
        for (int i = 0; i < MAX_R; i++) begin
            held_used[i] = 1'b0;
        end
        model_free    = model_arena;
        model_regions = 0;
        model_blocks  = 0;
    endfunction

    // One if a held region ends at lo, plus one if a held region starts at hi.
    function automatic int count_touching(input logic [63:0] lo, input logic [63:0] hi);
        bit left;
        bit right;
        left  = 1'b0;
        right = 1'b0;
        for (int i = 0; i < MAX_R; i++) begin
            if (held_used[i]) begin
                if (held_base[i] + held_len[i] == lo) left = 1'b1;
                if (held_base[i] == hi) right = 1'b1;
            end
        end
        return int'(left) + int'(right);
    endfunction

    function automatic alloc_result_t predict_request(input logic cmd, input logic [31:0] addr,
                                                      input logic [31:0] size);
        alloc_result_t r;
        logic [63:0]   lo;
        logic [63:0]   hi;
        t_status       st;
        int            slot;
        int            nb;
        lo   = {32'd0, addr};
        hi   = lo + {32'd0, size};
        st   = ST_OK;
        slot = -1;
        if (cmd == CMD_ALLOC) begin
            if (lo >= {32'd0, model_arena}) begin
                st = ST_START;
            end else if (size == 32'd0 || hi > {32'd0, model_arena}) begin
                st = ST_END;
            end else begin
                for (int i = 0; i < MAX_R; i++) begin
                    if (held_used[i] && lo < held_base[i] + held_len[i] && held_base[i] < hi)
                        st = ST_OVERLAP;
                end
                if (st == ST_OK) begin
                    for (int i = MAX_R - 1; i >= 0; i--) begin
                        if (!held_used[i]) slot = i;
                    end
                    if (slot < 0) st = ST_FULL;
                end
            end
            if (st == ST_OK) begin
                nb = count_touching(lo, hi);
                held_used[slot] = 1'b1;
                held_base[slot] = lo;
                held_len[slot]  = {32'd0, size};
                model_free      = model_free - size;
                model_regions++;
                model_blocks    = model_blocks + 1 - nb;
            end
        end else begin
            for (int i = MAX_R - 1; i >= 0; i--) begin
                if (held_used[i] && held_base[i] == lo) slot = i;
            end
            if (slot < 0) begin
                st = ST_BADFREE;
            end else begin
                held_used[slot] = 1'b0;
                nb = count_touching(lo, lo + held_len[slot]);
                model_free      = model_free + held_len[slot][31:0];
                model_regions--;
                model_blocks    = model_blocks + nb - 1;
            end
        end
        if (model_regions > peak_regions) peak_regions = model_regions;
        r.status  = st;
        r.free_b  = model_free;
        r.regions = model_regions[COUNT_W-1:0];
        r.blocks  = model_blocks[COUNT_W-1:0];
        return r;
    endfunction

    function automatic int pick_held();
        int n;
        n = $urandom_range(0, model_regions - 1);
        for (int i = 0; i < MAX_R; i++) begin
            if (held_used[i]) begin
                if (n == 0) return i;
                n--;
            end
        end
        return 0;
    endfunction

    // Random idle decision for one cycle.
    function automatic bit idle_roll(input int pct);
        if (pct == 0) return 1'b0;
        return ($urandom_range(0, 99) < pct);
    endfunction

    function automatic dir_row_t mk_word(input logic cmd, input logic [31:0] addr,
                                         input logic [31:0] size, input logic typed,
                                         input logic [STATUS_W-1:0] st, input logic [31:0] fb,
                                         input int rg, input int bk);
        dir_row_t r;
        r.kind        = ROW_WORD;
        r.cmd         = cmd;
        r.addr        = addr;
        r.size        = size;
        r.typed       = typed;
        r.exp.status  = st;
        r.exp.free_b  = fb;
        r.exp.regions = rg[COUNT_W-1:0];
        r.exp.blocks  = bk[COUNT_W-1:0];
        return r;
    endfunction

    function automatic dir_row_t mk_arena(input logic [31:0] value);
        dir_row_t r;
        r      = '0;
        r.kind = ROW_ARENA;
        r.addr = value;
        return r;
    endfunction

    function automatic void note_error(input string what);
        errors++;
        mismatches++;
        if (mismatches <= SHOW_LIMIT) $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    // Accepted request: run the predictor and queue what the block should answer.
    always @(posedge i_clk) begin
        alloc_result_t pred;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            pred = predict_request(i_command, i_address, i_region_size);
            pending_results.push_back(cur_typed ? cur_exp : pred);
            words_in++;
        end
    end

    always @(posedge i_clk) begin
        alloc_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            words_out++;
            if (!$isunknown(o_status)) status_seen[o_status]++;
            if (pending_results.size() == 0) begin
                note_error("result word with nothing outstanding");
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status)
                    note_error($sformatf("status exp %0d got %0d", want.status, o_status));
                if (o_free_bytes !== want.free_b)
                    note_error($sformatf("free_bytes exp 0x%08h got 0x%08h",
                                         want.free_b, o_free_bytes));
                if (o_regions_held !== want.regions)
                    note_error($sformatf("regions_held exp %0d got %0d",
                                         want.regions, o_regions_held));
                if (o_blocks_held !== want.blocks)
                    note_error($sformatf("blocks_held exp %0d got %0d",
                                         want.blocks, o_blocks_held));
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_ready <= !idle_roll(recv_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_MAX) begin
            $display("watchdog: no word moved for %0d cycles", STALL_MAX);
            $display("== FAIL ==");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_word(input logic cmd, input logic [31:0] addr, input logic [31:0] size,
                             input logic typed, input alloc_result_t exp);
        while (idle_roll(send_pct)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_address     <= addr;
        i_region_size <= size;
        cur_typed      = typed;
        cur_exp        = exp;
        @(posedge i_clk);
        while (!(i_in_valid && o_in_ready)) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_arena(input logic [31:0] value);
        hold_until_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        model_arena = value;
        clear_model();
        arena_writes++;
    endtask

    // Mostly well-formed traffic: allocations next to held regions, frees of held starts.
    task automatic gen_word(input bit fill, output logic cmd, output logic [31:0] addr,
                            output logic [31:0] size);
        int          roll;
        int          pick;
        int          k;
        logic [31:0] a;
        logic [31:0] span;
        a    = model_arena;
        roll = $urandom_range(0, 99);
        cmd  = CMD_ALLOC;
        addr = '0;
        size = '0;
        if (roll < 8) begin
            cmd  = 1'($urandom_range(0, 1));
            addr = $urandom;
            size = $urandom;
        end else if (roll < (fill ? 92 : 60)) begin
            pick = $urandom_range(0, 99);
            span = (pick < 70) ? (a >> 6) : (a >> 2);
            if (span == 0) span = 1;
            size = fill ? $urandom_range(1, 2) : $urandom_range(1, span);
            pick = $urandom_range(0, 99);
            if (model_regions > 0 && pick < (fill ? 75 : 25)) begin
                k    = pick_held();
                addr = held_base[k][31:0] + held_len[k][31:0];
            end else if (model_regions > 0 && pick < (fill ? 80 : 40)) begin
                k    = pick_held();
                addr = held_base[k][31:0] - size;
            end else begin
                addr = (a == 0) ? $urandom : $urandom_range(0, a - 1);
            end
            if (!fill) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) size = '0;
                else if (pick < 10) size = a - addr;
                else if (pick < 14) size = a - addr + 1;
            end
        end else begin
            cmd  = CMD_FREE;
            size = $urandom;
            if (model_regions > 0 && $urandom_range(0, 99) < 80)
                addr = held_base[pick_held()][31:0];
            else
                addr = (a == 0) ? $urandom : $urandom_range(0, a);
        end
    endtask

    initial begin
        logic          cmd;
        logic [31:0]   addr;
        logic [31:0]   size;
        logic [31:0]   arena;
        alloc_result_t none;

        none = '0;
        model_arena  = '0;
        peak_regions = 0;
        clear_model();
        foreach (status_seen[s]) status_seen[s] = 0;

        // Arena is zero out of reset, so nothing can be allocated or freed.
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd0, 32'd1, 1, ST_START, 32'd0, 0, 0));
        dir_rows.push_back(mk_word(CMD_FREE, 32'd0, 32'd0, 1, ST_BADFREE, 32'd0, 0, 0));
        dir_rows.push_back(mk_arena(32'd100));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd100, 32'd1, 1, ST_START, 32'd100, 0, 0));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd0, 32'd0, 1, ST_END, 32'd100, 0, 0));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd0, 32'd101, 1, ST_END, 32'd100, 0, 0));
        // The end wraps past the address space and must still be caught.
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd99, 32'hFFFF_FFFF, 1, ST_END, 32'd100, 0, 0));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'hFFFF_FFFF, 32'd1, 1, ST_START, 32'd100, 0, 0));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd10, 32'd10, 1, ST_OK, 32'd90, 1, 1));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd30, 32'd10, 0, ST_OK, 32'd0, 0, 0));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd20, 32'd10, 0, ST_OK, 32'd0, 0, 0));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd25, 32'd1, 1, ST_OVERLAP, 32'd70, 3, 1));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd0, 32'd11, 1, ST_OVERLAP, 32'd70, 3, 1));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd39, 32'd61, 1, ST_OVERLAP, 32'd70, 3, 1));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd40, 32'd60, 0, ST_OK, 32'd0, 0, 0));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd0, 32'd10, 0, ST_OK, 32'd0, 0, 0));
        dir_rows.push_back(mk_word(CMD_FREE, 32'd21, 32'd0, 1, ST_BADFREE, 32'd0, 5, 1));
        dir_rows.push_back(mk_word(CMD_FREE, 32'd20, 32'd0, 0, ST_OK, 32'd0, 0, 0));
        dir_rows.push_back(mk_word(CMD_FREE, 32'd10, 32'd0, 0, ST_OK, 32'd0, 0, 0));
        dir_rows.push_back(mk_arena(32'hFFFF_FFFF));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'd0, 32'hFFFF_FFFF, 1, ST_OK, 32'd0, 1, 1));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'hFFFF_FFFE, 32'd1, 1, ST_OVERLAP, 32'd0, 1, 1));
        dir_rows.push_back(mk_word(CMD_FREE, 32'd0, 32'd0, 1, ST_OK, 32'hFFFF_FFFF, 0, 0));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'hFFFF_FFFE, 32'd1, 1, ST_OK,
                                   32'hFFFF_FFFE, 1, 1));
        dir_rows.push_back(mk_word(CMD_ALLOC, 32'hFFFF_FFFF, 32'd1, 1, ST_START,
                                   32'hFFFF_FFFE, 1, 1));
        dir_rows.push_back(mk_word(CMD_FREE, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 1, ST_OK,
                                   32'hFFFF_FFFF, 0, 0));

        // Mode 0 no idling, 1 sender gaps, 2 receiver stalls, 3 both.
        ph_arena = '{32'd0, 32'd1000, 32'd200, 32'hFFFF_FFFF, 32'd64, 32'd0,
                     32'd1, 32'd4096, 32'd200, 32'h8000_0000, 32'd300};
        ph_items = '{30, 120, 130, 120, 100, 120, 30, 120, 130, 100, 100};
        ph_mode  = '{1, 0, 2, 3, 1, 2, 0, 3, 1, 2, 0};
        ph_fill  = '{0, 0, 1, 0, 0, 0, 0, 0, 1, 0, 0};

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_ARENA)
                write_arena(dir_rows[k].addr);
            else
                send_word(dir_rows[k].cmd, dir_rows[k].addr, dir_rows[k].size,
                          dir_rows[k].typed, dir_rows[k].exp);
        end

        for (int p = 0; p < PHASES; p++) begin
            arena = (p == 5) ? $urandom : ph_arena[p];
            write_arena(arena);
            send_pct = (ph_mode[p] == 1) ? 49 : (ph_mode[p] == 3) ? 8 : 0;
            recv_pct = (ph_mode[p] == 2) ? 49 : (ph_mode[p] == 3) ? 8 : 0;
            for (int n = 0; n < ph_items[p]; n++) begin
                // Let the block run completely dry once per phase.
                if (n == ph_items[p] / 2) hold_until_drained();
                gen_word(ph_fill[p], cmd, addr, size);
                send_word(cmd, addr, size, 1'b0, none);
            end
        end

        hold_until_drained();
        repeat (TAIL_WAIT) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0d expected results never arrived", pending_results.size());
        end

        $display("Ran %0d requests (%0d results) over %0d arena settings, peak %0d regions.",
                 words_in, words_out, arena_writes, peak_regions);
        $display("Status mix: ok %0d, start %0d, end %0d, overlap %0d, bad free %0d, full %0d.",
                 status_seen[ST_OK], status_seen[ST_START], status_seen[ST_END],
                 status_seen[ST_OVERLAP], status_seen[ST_BADFREE], status_seen[ST_FULL]);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d check failures", errors);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
hw/rtl/fara_pkg.sv
hw/rtl/fara_ram.sv
hw/rtl/fara_cmp.sv
hw/rtl/fixed_address_region_allocator_unit.sv
tb/tb_fixed_address_region_allocator_unit.sv
